// ===== sv/rfpa_pkg.sv =====
// rfpa_pkg: shared types and codes for the ring fork-pair arbiter
// holds the broadcast command, the chain link type, status and register codes
// no dependencies
package rfpa_pkg;

    localparam int SEAT_W = 4;
    localparam int RING_W = 5;
    localparam int MEAL_W = 16;
    localparam int TIME_IN_W = 32;
    localparam int STATUS_W = 3;

    // input kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SINGLE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OLDEST = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;

    // configuration register indexes
    localparam logic CFG_SEAT_COUNT  = 1'b0;
    localparam logic CFG_MEAL_TARGET = 1'b1;

    // reset values of the configuration registers
    localparam logic [RING_W-1:0] SEAT_COUNT_RST  = 5'd5;
    localparam logic [MEAL_W-1:0] MEAL_TARGET_RST = 16'd0;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              upd_grant;
        logic              upd_release;
        logic              meal_dec_en;
        logic              meal_load;
        logic [SEAT_W-1:0] seat;
        logic [RING_W-1:0] next_seat;
        logic [RING_W-1:0] ring_n;
        logic [MEAL_W-1:0] meal_value;
    } cell_cmd_t;

    // age-check token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic older;
    } link_t;

endpackage

// ===== sv/rfpa_cell.sv =====
// rfpa_cell: one seat of the ring, holding its resource flag, last grant time
// and remaining meal count, plus one stage of the age-check chain
// depends on rfpa_pkg
module rfpa_cell #(
    parameter int TIME_BITS = 32,
    parameter int CELL_IDX  = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rfpa_pkg::cell_cmd_t     cmd,
    input  logic [TIME_BITS-1:0]    grant_time,
    input  rfpa_pkg::link_t         link_in,
    input  logic [TIME_BITS-1:0]    ref_time_in,
    output rfpa_pkg::link_t         link_out,
    output logic [TIME_BITS-1:0]    ref_time_out,
    output logic                    taken,
    output logic [TIME_BITS-1:0]    last_time,
    output logic [rfpa_pkg::MEAL_W-1:0] meals
);
    import rfpa_pkg::*;

    localparam bit                ADDRESSABLE = CELL_IDX < (1 << SEAT_W);
    localparam bit                RING_FITS   = CELL_IDX < (1 << RING_W);
    localparam logic [SEAT_W-1:0] MY_SEAT     = SEAT_W'(CELL_IDX);
    localparam logic [RING_W-1:0] MY_RING_IDX = RING_W'(CELL_IDX);

    logic                 taken_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [MEAL_W-1:0]    meals_reg;
    link_t                link_reg;
    logic [TIME_BITS-1:0] ref_time_reg;
    logic                 seat_hit;
    logic                 next_hit;
    logic                 active;

    assign seat_hit = ADDRESSABLE && (cmd.seat == MY_SEAT);
    assign next_hit = RING_FITS && (cmd.next_seat == MY_RING_IDX);
    assign active   = RING_FITS && (MY_RING_IDX < cmd.ring_n);

    // seat state: grant, release, meal bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
            time_reg  <= '0;
            meals_reg <= MEAL_TARGET_RST;
        end
        else
        begin
            if (cmd.meal_load)
            begin
                meals_reg <= cmd.meal_value;
            end
            if (cmd.upd_grant)
            begin
                if (seat_hit || next_hit)
                begin
                    taken_reg <= 1'b1;
                end
                if (seat_hit)
                begin
                    time_reg <= grant_time;
                end
            end
            if (cmd.upd_release)
            begin
                if (seat_hit || next_hit)
                begin
                    taken_reg <= 1'b0;
                end
                if (seat_hit && cmd.meal_dec_en && (meals_reg != '0))
                begin
                    meals_reg <= meals_reg - MEAL_W'(1);
                end
            end
        end
    end

    // age-check stage: flag a strictly older grant time within the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg.valid <= link_in.valid;
            link_reg.older <= link_in.older
                              | (link_in.valid && active && (time_reg < ref_time_in));
        end
    end

    // reference time travels alongside the token
    always_ff @(posedge clk)
    begin
        ref_time_reg <= ref_time_in;
    end

    assign link_out     = link_reg;
    assign ref_time_out = ref_time_reg;
    assign taken        = taken_reg;
    assign last_time    = time_reg;
    assign meals        = meals_reg;

endmodule

// ===== sv/ring_fork_pair_arbiter_unit.sv =====
// Ring fork-pair arbiter: grants a seat its own resource and its neighbour's
// when both are free and no seat in the ring holds an older last grant time.
// Input stream: s_tvalid/s_tready, s_tdata = {now_time, seat}, s_tuser = kind
// (0 request, 1 release). Output stream: m_tvalid/m_tready,
// m_tdata = {meals_remaining, status, granted}. One result per input item.
// Configuration: cfg_we with cfg_index 0 writes seat_count, index 1 writes
// meal_target (reloading every seat's meal count); write only when idle.
// Timing: one item at a time. A release, a busy or single-seat request, or a
// seat outside the ring passes from acceptance through the evaluate and result
// states to m_tvalid; a request that reaches the age check also waits in the
// walk state while the token walks the row of seat cells one cell per cycle.
// The next item is accepted once the previous one has reached the output
// register, and one item may be in work while a result waits to be taken.
// If the receiver stalls with a result still waiting, the finished item holds
// in its last step until the output register frees.
// Reset clears all resource flags and grant times, sets seat_count to 5 and
// meal_target to 0, and empties the output register.
// depends on rfpa_pkg and rfpa_cell
module ring_fork_pair_arbiter_unit #(
    parameter int MAX_SEATS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] seat, [35:4] now_time, [39:36] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] granted, [3:1] status, [19:4] meals_remaining, [23:20] zero
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import rfpa_pkg::*;

    localparam logic [RING_W-1:0] MAX_RING = (MAX_SEATS > 31) ? RING_W'(31)
                                                              : RING_W'(MAX_SEATS);
    localparam int NSEL = (MAX_SEATS < (1 << SEAT_W)) ? MAX_SEATS : (1 << SEAT_W);
    localparam int NNXT = (MAX_SEATS < (1 << RING_W)) ? MAX_SEATS : (1 << RING_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t               state_reg;
    logic [RING_W-1:0]    seat_count_reg;
    logic [MEAL_W-1:0]    meal_target_reg;
    logic                 kind_reg;
    logic [SEAT_W-1:0]    seat_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [RING_W-1:0]    ring_n_reg;
    link_t                launch_reg;
    logic [TIME_BITS-1:0] launch_time_reg;
    logic                 res_granted_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [MEAL_W-1:0]    res_meals_reg;
    logic                 out_valid_reg;
    logic [23:0]          out_data_reg;

    cell_cmd_t            cmd;
    link_t                chain_link [0:MAX_SEATS];
    logic [TIME_BITS-1:0] chain_time [0:MAX_SEATS];
    logic                 cell_taken [0:MAX_SEATS-1];
    logic [TIME_BITS-1:0] cell_time  [0:MAX_SEATS-1];
    logic [MEAL_W-1:0]    cell_meals [0:MAX_SEATS-1];

    logic [RING_W-1:0]    ring_n;
    logic [RING_W-1:0]    seat_inc;
    logic [RING_W-1:0]    next_seat;
    logic                 in_ring;
    logic                 taken_s;
    logic                 taken_nx;
    logic [TIME_BITS-1:0] time_s;
    logic [MEAL_W-1:0]    meals_s;
    logic                 meal_dec;
    logic                 busy;
    logic                 in_accept;
    logic                 launch_go;
    logic                 out_load;

    // effective ring size, clamped to 1..MAX_SEATS
    always_comb
    begin
        if (seat_count_reg == '0)
        begin
            ring_n = RING_W'(1);
        end
        else if (seat_count_reg > MAX_RING)
        begin
            ring_n = MAX_RING;
        end
        else
        begin
            ring_n = seat_count_reg;
        end
    end

    // neighbour seat and ring membership of the held item
    assign seat_inc  = {1'b0, seat_reg} + RING_W'(1);
    assign next_seat = (seat_inc == ring_n_reg) ? '0 : seat_inc;
    assign in_ring   = {1'b0, seat_reg} < ring_n_reg;

    // read the addressed seats out of the row
    always_comb
    begin
        taken_s  = 1'b0;
        taken_nx = 1'b0;
        time_s   = '0;
        meals_s  = '0;
        for (int i = 0; i < NSEL; i++)
        begin
            if (seat_reg == SEAT_W'(i))
            begin
                taken_s = cell_taken[i];
                time_s  = cell_time[i];
                meals_s = cell_meals[i];
            end
        end
        for (int i = 0; i < NNXT; i++)
        begin
            if (next_seat == RING_W'(i))
            begin
                taken_nx = cell_taken[i];
            end
        end
    end

    assign meal_dec = (meal_target_reg != '0) && (meals_s != '0);
    assign busy     = taken_s || ((ring_n_reg > RING_W'(1)) && taken_nx);

    // command broadcast to the cells
    always_comb
    begin
        cmd             = '0;
        cmd.seat        = seat_reg;
        cmd.next_seat   = next_seat;
        cmd.ring_n      = ring_n_reg;
        cmd.meal_dec_en = meal_target_reg != '0;
        cmd.meal_value  = cfg_data;
        cmd.meal_load   = cfg_we && (cfg_index == CFG_MEAL_TARGET);
        cmd.upd_release = (state_reg == ST_EVAL) && in_ring && (kind_reg == KIND_RELEASE);
        cmd.upd_grant   = (state_reg == ST_WALK) && chain_link[MAX_SEATS].valid
                          && !chain_link[MAX_SEATS].older;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seat_count_reg  <= SEAT_COUNT_RST;
            meal_target_reg <= MEAL_TARGET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEAT_COUNT:  seat_count_reg  <= cfg_data[RING_W-1:0];
                CFG_MEAL_TARGET: meal_target_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;

    // age-check launch for a free request in a ring of two or more seats
    assign launch_go = (state_reg == ST_EVAL) && in_ring && (kind_reg == KIND_REQUEST)
                       && !busy && (ring_n_reg > RING_W'(1));
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);

    // item sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            launch_reg      <= '0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= KIND_REQUEST;
            seat_reg        <= '0;
            now_reg         <= '0;
            ring_n_reg      <= RING_W'(1);
            launch_time_reg <= '0;
            res_granted_reg <= 1'b0;
            res_status_reg  <= ST_GRANTED;
            res_meals_reg   <= '0;
            out_data_reg    <= '0;
        end
        else
        begin
            launch_reg.valid <= launch_go;
            launch_reg.older <= 1'b0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        kind_reg   <= s_tuser;
                        seat_reg   <= s_tdata[SEAT_W-1:0];
                        now_reg    <= TIME_BITS'(s_tdata[SEAT_W +: TIME_IN_W]);
                        ring_n_reg <= ring_n;
                        state_reg  <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    res_granted_reg <= 1'b0;
                    if (!in_ring)
                    begin
                        res_meals_reg  <= '0;
                        res_status_reg <= (kind_reg == KIND_RELEASE) ? ST_RELEASED : ST_BUSY;
                        state_reg      <= ST_RESULT;
                    end
                    else if (kind_reg == KIND_RELEASE)
                    begin
                        res_status_reg <= ST_RELEASED;
                        res_meals_reg  <= meals_s - MEAL_W'(meal_dec);
                        state_reg      <= ST_RESULT;
                    end
                    else if (busy)
                    begin
                        res_status_reg <= ST_BUSY;
                        res_meals_reg  <= meals_s;
                        state_reg      <= ST_RESULT;
                    end
                    else if (ring_n_reg <= RING_W'(1))
                    begin
                        res_status_reg <= ST_SINGLE;
                        res_meals_reg  <= meals_s;
                        state_reg      <= ST_RESULT;
                    end
                    else
                    begin
                        // start the age-check token down the row
                        res_meals_reg   <= meals_s;
                        launch_time_reg <= time_s;
                        state_reg       <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (chain_link[MAX_SEATS].valid)
                    begin
                        res_granted_reg <= !chain_link[MAX_SEATS].older;
                        res_status_reg  <= chain_link[MAX_SEATS].older ? ST_NOT_OLDEST
                                                                       : ST_GRANTED;
                        state_reg       <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (out_load)
                    begin
                        out_data_reg <= {4'd0, res_meals_reg, res_status_reg, res_granted_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // row of seat cells
    assign chain_link[0] = launch_reg;
    assign chain_time[0] = launch_time_reg;

    for (genvar g = 0; g < MAX_SEATS; g++)
    begin : g_cell
        rfpa_cell #(
            .TIME_BITS (TIME_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .grant_time   (now_reg),
            .link_in      (chain_link[g]),
            .ref_time_in  (chain_time[g]),
            .link_out     (chain_link[g+1]),
            .ref_time_out (chain_time[g+1]),
            .taken        (cell_taken[g]),
            .last_time    (cell_time[g]),
            .meals        (cell_meals[g])
        );
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sv/ring_fork_pair_arbiter_unit_tb.sv =====
// ring_fork_pair_arbiter_unit_tb: self-checking bench for the ring fork-pair arbiter
// checks every result against its own arbitration predictor or a typed directed row, under random idling
// depends on rfpa_pkg and ring_fork_pair_arbiter_unit
`timescale 1ns / 100ps

module ring_fork_pair_arbiter_unit_tb;

    import rfpa_pkg::*;

    localparam int SEATS          = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 250;
    localparam int NUM_PHASES     = 8;
    localparam int PLAN_ROWS      = 30;

    // one predicted result
    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [MEAL_W-1:0]   meals;
    } grant_outcome_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

    // directed row: an item (kind, seat, stamp) or a register write (index, value)
    typedef struct {
        row_op_t             op;
        logic                sel;
        logic [SEAT_W-1:0]   seat;
        logic [31:0]         value;
        bit                  typed;
        logic                want_granted;
        logic [STATUS_W-1:0] want_status;
        logic [MEAL_W-1:0]   want_meals;
    } plan_row_t;

    typedef struct {
        int          send_pct;
        int          recv_pct;
        logic [15:0] seats;
        logic [15:0] meals;
        bit          long_hold;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [3:0] seat, [35:4] now_time, [39:36] zero
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [0] granted, [3:1] status, [19:4] meals_remaining, [23:20] zero
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // arbitration predictor state
    bit                ring_res_taken [SEATS];
    logic [31:0]       ring_grant_stamp [SEATS];
    logic [MEAL_W-1:0] ring_meals_left [SEATS];
    logic [RING_W-1:0] ring_cfg_seats;
    logic [MEAL_W-1:0] ring_cfg_meals;

    grant_outcome_t    outcomes_due [$];
    grant_outcome_t    oldest_due;
    logic [SEAT_W-1:0] seats_holding [$];
    logic [31:0]       clock_ms;
    int                mismatches;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_pending;
    int                hold_left;
    int                stalled_cycles;

    plan_row_t directed_plan [PLAN_ROWS] = '{
        // first grant on a fresh ring, then neighbour and wrap-around clashes
        '{ROW_ITEM,  KIND_REQUEST, 4'd0,  32'd100,        1, 1'b1, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd1,  32'd200,        1, 1'b0, ST_BUSY,       16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd4,  32'd300,        1, 1'b0, ST_BUSY,       16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd2,  32'hFFFF_FFFF,  1, 1'b1, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd0,  32'd0,          1, 1'b0, ST_RELEASED,   16'd0},
        // free but another seat waited longer
        '{ROW_ITEM,  KIND_REQUEST, 4'd0,  32'd5,          1, 1'b0, ST_NOT_OLDEST, 16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd1,  32'd7,          1, 1'b0, ST_BUSY,       16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd2,  32'd0,          0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd1,  32'd7,          0, 1'b0, ST_GRANTED,    16'd0},
        // seat outside the ring
        '{ROW_ITEM,  KIND_REQUEST, 4'd15, 32'd0,          1, 1'b0, ST_BUSY,       16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd15, 32'hFFFF_FFFF,  1, 1'b0, ST_RELEASED,   16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd1,  32'd0,          0, 1'b0, ST_GRANTED,    16'd0},
        // meal counting down to zero and holding there
        '{ROW_WRITE, CFG_MEAL_TARGET, 4'd0, 32'd2,        0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd3,  32'd0,          1, 1'b0, ST_RELEASED,   16'd1},
        '{ROW_ITEM,  KIND_RELEASE, 4'd3,  32'd0,          1, 1'b0, ST_RELEASED,   16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd3,  32'd0,          1, 1'b0, ST_RELEASED,   16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd4,  32'd50,         0, 1'b0, ST_GRANTED,    16'd0},
        // single seat ring
        '{ROW_WRITE, CFG_SEAT_COUNT, 4'd0, 32'd1,         0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd0,  32'd1,          0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd0,  32'd0,          0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd0,  32'd1,          1, 1'b0, ST_SINGLE,     16'd1},
        '{ROW_ITEM,  KIND_REQUEST, 4'd1,  32'd0,          1, 1'b0, ST_BUSY,       16'd0},
        // full ring, largest meal target
        '{ROW_WRITE, CFG_SEAT_COUNT, 4'd0, 32'd16,        0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_WRITE, CFG_MEAL_TARGET, 4'd0, 32'd65535,    0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd15, 32'hFFFF_FFFF,  0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_RELEASE, 4'd15, 32'd0,          1, 1'b0, ST_RELEASED,   16'hFFFE},
        // ring size clamped at both ends
        '{ROW_WRITE, CFG_SEAT_COUNT, 4'd0, 32'd0,         0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd0,  32'd0,          0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_WRITE, CFG_SEAT_COUNT, 4'd0, 32'd31,        0, 1'b0, ST_GRANTED,    16'd0},
        '{ROW_ITEM,  KIND_REQUEST, 4'd9,  32'd123,        0, 1'b0, ST_GRANTED,    16'd0}
    };

    phase_t phases [NUM_PHASES] = '{
        '{0,  0,  16'd5,  16'd0,     0},
        '{68, 0,  16'd16, 16'd3,     0},
        '{0,  68, 16'd2,  16'd65535, 0},
        '{38, 38, 16'd7,  16'd1,     0},
        '{0,  0,  16'd16, 16'd0,     1},
        '{68, 0,  16'd3,  16'd2,     0},
        '{0,  68, 16'd1,  16'd5,     0},
        '{38, 38, 16'd9,  16'd40000, 0}
    };

    ring_fork_pair_arbiter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // effective ring size after clamping
    function automatic int ring_seats();
        int n;
        n = int'(ring_cfg_seats);
        if (n < 1)
            n = 1;
        if (n > SEATS)
            n = SEATS;
        return n;
    endfunction

    // predicted outcome of one transaction, updating the ring state
    function automatic grant_outcome_t predict_arbitration(input logic kind,
                                                           input logic [SEAT_W-1:0] seat,
                                                           input logic [31:0] stamp);
        grant_outcome_t res;
        int  n;
        int  nxt;
        bit  busy;
        bit  older;
        n = ring_seats();
        res.granted = 1'b0;
        res.status  = ST_BUSY;
        res.meals   = '0;
        if (seat >= n)
        begin
            res.status = (kind == KIND_RELEASE) ? ST_RELEASED : ST_BUSY;
        end
        else
        begin
            nxt = (seat + 1) % n;
            if (kind == KIND_RELEASE)
            begin
                ring_res_taken[nxt]  = 1'b0;
                ring_res_taken[seat] = 1'b0;
                if (ring_cfg_meals != 0 && ring_meals_left[seat] != 0)
                    ring_meals_left[seat] = ring_meals_left[seat] - 1'b1;
                res.status = ST_RELEASED;
            end
            else
            begin
                busy  = ring_res_taken[seat] || (n > 1 && ring_res_taken[nxt]);
                older = 1'b0;
                for (int i = 0; i < n; i++)
                    if (ring_grant_stamp[i] < ring_grant_stamp[seat])
                        older = 1'b1;
                if (busy)
                    res.status = ST_BUSY;
                else if (n <= 1)
                    res.status = ST_SINGLE;
                else if (older)
                    res.status = ST_NOT_OLDEST;
                else
                begin
                    ring_res_taken[nxt]    = 1'b1;
                    ring_res_taken[seat]   = 1'b1;
                    ring_grant_stamp[seat] = stamp;
                    res.granted            = 1'b1;
                    res.status             = ST_GRANTED;
                end
            end
            res.meals = ring_meals_left[seat];
        end
        return res;
    endfunction

    // register write, issued only once every result has been taken
    task automatic write_register(input logic sel, input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_SEAT_COUNT)
        begin
            ring_cfg_seats = value[RING_W-1:0];
        end
        else
        begin
            ring_cfg_meals = value;
            for (int i = 0; i < SEATS; i++)
                ring_meals_left[i] = value;
        end
        @(posedge clk);
    endtask

    // offer one transaction, predict it once accepted
    task automatic send_item(input logic kind, input logic [SEAT_W-1:0] seat,
                             input logic [31:0] stamp, input bit typed,
                             input grant_outcome_t want);
        grant_outcome_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, stamp, seat};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = predict_arbitration(kind, seat, stamp);
        outcomes_due.push_back(typed ? want : got);
        if (got.granted)
            seats_holding.push_back(seat);
        if (kind == KIND_RELEASE && seat < ring_seats())
            for (int k = seats_holding.size() - 1; k >= 0; k--)
                if (seats_holding[k] == seat)
                    seats_holding.delete(k);
    endtask

    // random transaction: mostly the oldest seat asking and holders letting go
    task automatic next_random_item(output logic kind, output logic [SEAT_W-1:0] seat,
                                    output logic [31:0] stamp);
        int n;
        int pick;
        int start;
        int cand;
        n     = ring_seats();
        pick  = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(1, 3000);
        stamp = clock_ms;
        kind  = KIND_REQUEST;
        if (pick >= 45 && pick < 75 && seats_holding.size() != 0)
        begin
            kind = KIND_RELEASE;
            seat = seats_holding[$urandom_range(seats_holding.size() - 1)];
        end
        else if (pick < 75)
        begin
            start = $urandom_range(n - 1);
            seat  = SEAT_W'(start);
            for (int i = 1; i < n; i++)
            begin
                cand = (start + i) % n;
                if (ring_grant_stamp[cand] < ring_grant_stamp[seat])
                    seat = SEAT_W'(cand);
            end
        end
        else if (pick < 90)
        begin
            seat = SEAT_W'($urandom_range(n - 1));
        end
        else
        begin
            kind  = 1'($urandom_range(1));
            seat  = SEAT_W'($urandom_range(SEATS - 1));
            stamp = $urandom;
        end
    endtask

    // let every holder go so the ring is clear before a register change
    task automatic release_holders();
        grant_outcome_t none;
        none = '0;
        while (seats_holding.size() != 0)
            send_item(KIND_RELEASE, seats_holding[0], $urandom, 0, none);
    endtask

    // receiver: random stalls plus one long hold-off when asked
    initial
    begin
        m_tready  <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result with nothing pending: m_tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                oldest_due = outcomes_due.pop_front();
                if (m_tdata[0] !== oldest_due.granted)
                begin
                    $error("granted: expected %0d, actual %0d", oldest_due.granted, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[3:1] !== oldest_due.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_due.status, m_tdata[3:1]);
                    mismatches++;
                end
                if (m_tdata[19:4] !== oldest_due.meals)
                begin
                    $error("meals_remaining: expected %0d, actual %0d",
                           oldest_due.meals, m_tdata[19:4]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        grant_outcome_t      want;
        logic                kind;
        logic [SEAT_W-1:0]   seat;
        logic [31:0]         stamp;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= 1'b0;
        cfg_data       <= '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        clock_ms       = 32'd1000;
        ring_cfg_seats = SEAT_COUNT_RST;
        ring_cfg_meals = MEAL_TARGET_RST;
        for (int i = 0; i < SEATS; i++)
        begin
            ring_res_taken[i]   = 1'b0;
            ring_grant_stamp[i] = '0;
            ring_meals_left[i]  = MEAL_TARGET_RST;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (directed_plan[r].op == ROW_WRITE)
            begin
                write_register(directed_plan[r].sel, directed_plan[r].value[15:0]);
            end
            else
            begin
                want.granted = directed_plan[r].want_granted;
                want.status  = directed_plan[r].want_status;
                want.meals   = directed_plan[r].want_meals;
                send_item(directed_plan[r].sel, directed_plan[r].seat,
                          directed_plan[r].value, directed_plan[r].typed, want);
            end
        end
        release_holders();

        // random phases, each with its own ring size, meal target and idling
        want = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(CFG_SEAT_COUNT, phases[p].seats);
            write_register(CFG_MEAL_TARGET, phases[p].meals);
            send_idle_pct  = phases[p].send_pct;
            recv_stall_pct = phases[p].recv_pct;
            if (phases[p].long_hold)
                hold_pending = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                next_random_item(kind, seat, stamp);
                send_item(kind, seat, stamp, 0, want);
            end
            release_holders();
        end

        // wait out the remaining results
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rfpa_pkg.sv
sv/rfpa_cell.sv
sv/ring_fork_pair_arbiter_unit.sv
tb/sv/ring_fork_pair_arbiter_unit_tb.sv
